// ===== hdl/cse_pkg.sv =====
// Shared types, constants and helpers of the configuration space enumerator.
// Used by modules cse_ctrl, cse_dp and config_space_enumerator.
package cse_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SRCH_W = (CNT_W > 7) ? CNT_W : 7;

  // Opcodes
  localparam logic [2:0] OP_START      = 3'd0;
  localparam logic [2:0] OP_DATA       = 3'd1;
  localparam logic [2:0] OP_FIND_ID    = 3'd2;
  localparam logic [2:0] OP_FIND_CLASS = 3'd3;
  localparam logic [2:0] OP_GET        = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_REQ  = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_HIT  = 3'd2;
  localparam logic [2:0] ST_MISS = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;

  // Scan phases
  localparam logic [1:0] PH_ID    = 2'd0;
  localparam logic [1:0] PH_CLASS = 2'd1;
  localparam logic [1:0] PH_IRQ   = 2'd2;
  localparam logic [1:0] PH_HDR   = 2'd3;

  localparam logic [15:0] VENDOR_NONE  = 16'hFFFF;
  localparam logic [7:0]  SUB_ANY      = 8'hFF;
  localparam logic [7:0]  OFFSET_MASK  = 8'hFC;
  localparam logic [8:0]  BUS_MAX      = 9'd256;
  localparam logic [8:0]  BUS_COUNT_RST = 9'd8;

  localparam int ID_W   = 32;
  localparam int INFO_W = 48;

  typedef enum logic [1:0] {
    MODE_ID,
    MODE_CLASS,
    MODE_INDEX
  } mode_e;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SEARCH
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] read_data;
    logic [15:0] key_vendor;
    logic [15:0] key_device;
    logic [7:0]  key_class;
    logic [7:0]  key_subclass;
    logic [5:0]  query_index;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] request_address;
    logic [6:0]  device_count;
    logic [5:0]  entry_index;
    logic [15:0] location;
    logic [15:0] vendor_id;
    logic [15:0] device_id;
    logic [7:0]  class_code;
    logic [7:0]  subclass_code;
    logic [7:0]  prog_interface;
    logic [7:0]  irq_line;
  } out_req_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic take_data;
    logic bad;
    logic query_begin;
    logic step;
    logic load_hit;
    logic load_miss;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scanning;
    logic out_busy;
    logic hit;
    logic exhausted;
  } sts_t;

  // Configuration offset read in each scan phase
  function automatic logic [7:0] phase_offset(input logic [1:0] ph);
    logic [7:0] off;
    unique case (ph)
      PH_ID:    off = 8'h00;
      PH_CLASS: off = 8'h08;
      PH_IRQ:   off = 8'h3C;
      default:  off = 8'h0C;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/cse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/cse_ctrl.sv =====
// Controller of the enumerator: accepts requests, sequences table searches.
// Depends on cse_pkg; drives cse_dp through cmd_t and reads sts_t.
module cse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    opcode_i,
  input  cse_pkg::sts_t sts_i,
  output cse_pkg::cmd_t cmd_o
);
  import cse_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Stall while searching or while a held result cannot leave
  assign in_stall_o = (state_q != S_IDLE) || sts_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == OP_FIND_ID || opcode_i == OP_FIND_CLASS ||
                       opcode_i == OP_GET)) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.hit || sts_i.exhausted) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_START: cmd_o.start = 1'b1;
            OP_DATA: begin
              if (sts_i.scanning) begin
                cmd_o.take_data = 1'b1;
              end else begin
                cmd_o.bad = 1'b1;
              end
            end
            OP_FIND_ID, OP_FIND_CLASS, OP_GET: cmd_o.query_begin = 1'b1;
            default: cmd_o.bad = 1'b1;
          endcase
        end
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.hit) begin
          cmd_o.load_hit = 1'b1;
        end else if (sts_i.exhausted) begin
          cmd_o.load_miss = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/cse_dp.sv =====
// Datapath of the enumerator: scan position, device table, search pipe, result register.
// Depends on cse_pkg and cse_ram.
module cse_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [8:0]        cfg_data_i,
  input  cse_pkg::in_req_t  in_data_i,
  input  cse_pkg::cmd_t     cmd_i,
  output cse_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cse_pkg::out_req_t out_data_o
);
  import cse_pkg::*;

  // Configuration and scan state
  logic [8:0]        bus_count_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [7:0]        bus_q, bus_d;
  logic [4:0]        slot_q, slot_d;
  logic [2:0]        func_q, func_d;
  logic [1:0]        phase_q, phase_d;
  logic              scanning_q, scanning_d;
  logic [31:0]       held_id_q, held_id_d;
  logic [23:0]       held_class_q, held_class_d;

  // Search state
  mode_e             mode_q;
  logic [15:0]       key_vendor_q, key_device_q;
  logic [7:0]        key_class_q, key_sub_q;
  logic [SRCH_W-1:0] rd_idx_q;
  logic [IDX_W-1:0]  pipe_idx_q;
  logic              pipe_v_q;

  // Result register
  out_req_t          res_q, res_d;
  logic              out_valid_q;

  // Table
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ID_W-1:0]   id_wdata, id_rdata;
  logic [INFO_W-1:0] info_wdata, info_rdata;
  logic              rd_more;
  logic              match;
  logic              done_scan;
  logic [8:0]        bus_limit;

  cse_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (id_wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (id_rdata)
  );

  cse_ram #(.WIDTH(INFO_W), .DEPTH(TABLE_DEPTH)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (info_wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (info_rdata)
  );

  // Clamp bus count to one through 256
  always_comb begin
    if (bus_count_q == 9'd0) begin
      bus_limit = 9'd1;
    end else if (bus_count_q > BUS_MAX) begin
      bus_limit = BUS_MAX;
    end else begin
      bus_limit = bus_count_q;
    end
  end

  assign ram_waddr  = count_q[IDX_W-1:0];
  assign id_wdata   = held_id_q;
  assign info_wdata = {bus_q, slot_q, func_q, held_class_q, in_data_i.read_data[7:0]};
  assign ram_we     = cmd_i.take_data && (phase_q == PH_IRQ) &&
                      (count_q < CNT_W'(TABLE_DEPTH));

  // Scan walk: next position for a data response
  always_comb begin
    logic adv_func;
    logic adv_slot;
    logic [31:0] d;
    d            = in_data_i.read_data;
    adv_func     = 1'b0;
    adv_slot     = 1'b0;
    count_d      = count_q;
    bus_d        = bus_q;
    slot_d       = slot_q;
    func_d       = func_q;
    phase_d      = phase_q;
    scanning_d   = scanning_q;
    held_id_d    = held_id_q;
    held_class_d = held_class_q;
    done_scan    = 1'b0;
    if (cmd_i.start) begin
      count_d    = '0;
      bus_d      = '0;
      slot_d     = '0;
      func_d     = '0;
      phase_d    = PH_ID;
      scanning_d = 1'b1;
    end else if (cmd_i.take_data) begin
      unique case (phase_q)
        PH_ID: begin
          if (d[15:0] == VENDOR_NONE) begin
            if (func_q == 3'd0) begin
              adv_slot = 1'b1;
            end else begin
              adv_func = 1'b1;
            end
          end else begin
            held_id_d = d;
            phase_d   = PH_CLASS;
          end
        end
        PH_CLASS: begin
          held_class_d = d[31:8];
          phase_d      = PH_IRQ;
        end
        PH_IRQ: begin
          if (ram_we) begin
            count_d = count_q + CNT_W'(1);
          end
          phase_d = PH_HDR;
        end
        default: begin
          if (func_q == 3'd0 && !d[23]) begin
            adv_slot = 1'b1;
          end else begin
            adv_func = 1'b1;
          end
        end
      endcase
      // Next function, or next slot after function seven
      if (adv_func) begin
        phase_d = PH_ID;
        if (func_q == 3'd7) begin
          adv_slot = 1'b1;
        end else begin
          func_d = func_q + 3'd1;
        end
      end
      // Next slot, then next bus, then finish
      if (adv_slot) begin
        phase_d = PH_ID;
        func_d  = '0;
        if (slot_q == 5'd31) begin
          slot_d = '0;
          if ({1'b0, bus_q} + 9'd1 >= bus_limit) begin
            scanning_d = 1'b0;
            bus_d      = '0;
            done_scan  = 1'b1;
          end else begin
            bus_d = bus_q + 8'd1;
          end
        end else begin
          slot_d = slot_q + 5'd1;
        end
      end
    end
  end

  // Compare the entry read last cycle against the key; index mode takes any entry
  always_comb begin
    unique case (mode_q)
      MODE_ID:    match = (id_rdata[15:0] == key_vendor_q) &&
                          (id_rdata[31:16] == key_device_q);
      MODE_CLASS: match = (info_rdata[31:24] == key_class_q) &&
                          ((key_sub_q == SUB_ANY) || (info_rdata[23:16] == key_sub_q));
      default:    match = 1'b1;
    endcase
  end

  assign rd_more = rd_idx_q < SRCH_W'(count_q);

  assign sts_o.scanning  = scanning_q;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;
  assign sts_o.hit       = pipe_v_q && match;
  assign sts_o.exhausted = !pipe_v_q && !rd_more;

  // Build the next result
  always_comb begin
    res_d              = '0;
    res_d.device_count = 7'(count_d);
    if (cmd_i.start || cmd_i.take_data) begin
      if (done_scan) begin
        res_d.status = ST_DONE;
      end else begin
        res_d.status          = ST_REQ;
        res_d.request_address = {1'b1, 7'd0, bus_d, slot_d, func_d,
                                 phase_offset(phase_d) & OFFSET_MASK};
      end
    end else if (cmd_i.load_hit) begin
      res_d.status         = ST_HIT;
      res_d.entry_index    = 6'(pipe_idx_q);
      res_d.location       = info_rdata[47:32];
      res_d.vendor_id      = id_rdata[15:0];
      res_d.device_id      = id_rdata[31:16];
      res_d.class_code     = info_rdata[31:24];
      res_d.subclass_code  = info_rdata[23:16];
      res_d.prog_interface = info_rdata[15:8];
      res_d.irq_line       = info_rdata[7:0];
    end else if (cmd_i.load_miss) begin
      res_d.status = ST_MISS;
    end else begin
      res_d.status = ST_BAD;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_count_q  <= BUS_COUNT_RST;
      count_q      <= '0;
      bus_q        <= '0;
      slot_q       <= '0;
      func_q       <= '0;
      phase_q      <= PH_ID;
      scanning_q   <= 1'b0;
      held_id_q    <= '0;
      held_class_q <= '0;
      pipe_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        bus_count_q <= cfg_data_i;
      end
      count_q      <= count_d;
      bus_q        <= bus_d;
      slot_q       <= slot_d;
      func_q       <= func_d;
      phase_q      <= phase_d;
      scanning_q   <= scanning_d;
      held_id_q    <= held_id_d;
      held_class_q <= held_class_d;
      // Search pipe: one read per cycle, compared the cycle after
      if (cmd_i.query_begin) begin
        pipe_v_q <= 1'b0;
      end else if (cmd_i.step) begin
        pipe_v_q <= rd_more && !sts_o.hit;
      end
      // Result register: load on any result, drop when taken
      if (cmd_i.start || cmd_i.take_data || cmd_i.bad || cmd_i.load_hit ||
          cmd_i.load_miss) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_begin) begin
      key_vendor_q <= in_data_i.key_vendor;
      key_device_q <= in_data_i.key_device;
      key_class_q  <= in_data_i.key_class;
      key_sub_q    <= in_data_i.key_subclass;
      unique case (in_data_i.opcode)
        OP_FIND_ID: begin
          mode_q   <= MODE_ID;
          rd_idx_q <= '0;
        end
        OP_FIND_CLASS: begin
          mode_q   <= MODE_CLASS;
          rd_idx_q <= '0;
        end
        default: begin
          mode_q   <= MODE_INDEX;
          rd_idx_q <= SRCH_W'(in_data_i.query_index);
        end
      endcase
    end else if (cmd_i.step && rd_more) begin
      pipe_idx_q <= rd_idx_q[IDX_W-1:0];
      rd_idx_q   <= rd_idx_q + SRCH_W'(1);
    end
    if (cmd_i.start || cmd_i.take_data || cmd_i.bad || cmd_i.load_hit ||
        cmd_i.load_miss) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("device count beyond table depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_d == count_q + CNT_W'(1)))
    else $error("table write without count advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(cmd_i.start || cmd_i.take_data || cmd_i.bad ||
                                        cmd_i.load_hit || cmd_i.load_miss))
    else $error("result loaded over a held result");

  a_hit_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && sts_o.hit) |-> (CNT_W'(pipe_idx_q) < count_q))
    else $error("search hit outside stored entries");
`endif

endmodule

// ===== hdl/config_space_enumerator.sv =====
// Top level of the configuration space enumerator.
// Depends on cse_pkg, cse_ctrl, cse_dp (which holds two cse_ram tables).
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  cse_pkg::in_req_t
// out      output     out_valid_o/out_stall_i cse_pkg::out_req_t
// cfg      input      cfg_valid_i/cfg_ready_o bus count, 9 bits
//
// Start, read data and bad opcodes load the result register directly.
// Find id and find class walk the table one entry per cycle through the
// registered RAM read. Get by index reads the single indexed entry and misses
// when the index is not below the count. One request is in flight at a time.
// Reset clears the scan state and the count; table contents need no clearing.
// A held result stalls the input only when the output side also stalls.
module config_space_enumerator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cse_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cse_pkg::out_req_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_data_i
);
  import cse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  cse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (in_data_i.opcode),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
